FILE: rtl/pee_pkg.sv
// Shared types, constants and helpers for the percent escape encoder.
// No dependencies; imported by every module of the block.
package pee_pkg;

  localparam int unsigned CAP_W        = 16;
  localparam int unsigned COUNT_EXT_W  = CAP_W + 1;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd512;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [3:0] NIBBLE_MAX = 4'd15;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PLAIN,
    CMD_ESC
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic       term;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n > 4'd9) begin
      d = 8'h41 + {4'd0, n - 4'd10};
    end else begin
      d = 8'h30 + {4'd0, n};
    end
    return d;
  endfunction

  function automatic logic needs_escape(input logic [7:0] c, input logic first);
    logic e;
    e = (c inside {CH_SPACE, CH_STAR, CH_QUERY, CH_PCT}) || (c < CH_SPACE) ||
        (c > CH_TILDE) || ((c == CH_DOT) && first);
    return e;
  endfunction

endpackage

FILE: rtl/pee_front.sv
// Front end: accepts input transactions, classifies each character and
// tracks per-string state and the capacity register. Uses pee_pkg.
module pee_front import pee_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             end_of_string,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  input  q_status_t        q_status,
  output logic             push,
  output cmd_t             push_cmd
);

  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] written_count;
  logic             past_first;
  logic             halted;

  logic             accept;
  logic             has_char;
  logic             esc;
  logic             fit_esc;
  logic             fit_plain;
  cmd_kind_t        kind;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    has_char  = (in_byte != CH_NUL) && !halted;
    esc       = needs_escape(in_byte, !past_first);
    // compare one bit wider so the count plus the bytes to add never wraps
    fit_esc   = ({1'b0, written_count} + COUNT_EXT_W'(4)) < {1'b0, capacity};
    fit_plain = ({1'b0, written_count} + COUNT_EXT_W'(1)) < {1'b0, capacity};
    kind      = CMD_NONE;
    if (has_char) begin
      if (esc) begin
        kind = fit_esc ? CMD_ESC : CMD_NONE;
      end else begin
        kind = fit_plain ? CMD_PLAIN : CMD_NONE;
      end
    end
    push          = accept && ((kind != CMD_NONE) || end_of_string);
    push_cmd.kind = kind;
    push_cmd.ch   = in_byte;
    push_cmd.term = end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      written_count <= '0;
      past_first    <= 1'b0;
      halted        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        if (end_of_string) begin
          written_count <= '0;
          past_first    <= 1'b0;
          halted        <= 1'b0;
        end else if (has_char) begin
          if (esc && !fit_esc) begin
            halted <= 1'b1;
          end else begin
            past_first <= 1'b1;
          end
          if (kind == CMD_ESC) begin
            written_count <= written_count + CAP_W'(3);
          end else if (kind == CMD_PLAIN) begin
            written_count <= written_count + CAP_W'(1);
          end
        end
      end
    end
  end

endmodule

FILE: rtl/pee_queue.sv
// Short command queue between the front end and the emitter.
// Uses pee_pkg for the command and status types.
module pee_queue import pee_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.empty = (fill == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/pee_back.sv
// Emitter: expands each queued command into output bytes, one per cycle while
// out_stall is low, through a registered output stage. Uses pee_pkg.
module pee_back import pee_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last
);

  logic [1:0] pos;
  logic       load;
  logic [7:0] sel_byte;
  logic       sel_last;
  logic       final_byte;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !q_status.empty && final_byte;

  always_comb begin
    sel_byte   = CH_NUL;
    sel_last   = 1'b1;
    final_byte = 1'b1;
    case (head.kind)
      CMD_ESC: begin
        case (pos)
          2'd0: begin
            sel_byte = CH_PCT;
            sel_last = 1'b0;
            final_byte = 1'b0;
          end
          2'd1: begin
            sel_byte = hex_digit(head.ch[7:4]);
            sel_last = 1'b0;
            final_byte = 1'b0;
          end
          2'd2: begin
            sel_byte = hex_digit(head.ch[3:0] & NIBBLE_MAX);
            sel_last = 1'b0;
            final_byte = !head.term;
          end
          default: begin
            sel_byte = CH_NUL;
            sel_last = 1'b1;
            final_byte = 1'b1;
          end
        endcase
      end
      CMD_PLAIN: begin
        if (pos == 2'd0) begin
          sel_byte = head.ch;
          sel_last = 1'b0;
          final_byte = !head.term;
        end
      end
      default: begin
        sel_byte   = CH_NUL;
        sel_last   = 1'b1;
        final_byte = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= !q_status.empty;
      if (!q_status.empty) begin
        out_byte <= sel_byte;
        last     <= sel_last;
        // advance through the command, drop it on its final byte
        pos      <= final_byte ? 2'd0 : pos + 2'd1;
      end
    end
  end

endmodule

FILE: rtl/percent_escape_encoder.sv
// Top level of the percent escape encoder: front end, command queue and
// emitter. Depends on pee_pkg, pee_front, pee_queue and pee_back.
//
// Input channel (in_valid / in_stall): one transaction carries one byte of
// a string and its end_of_string flag; in_byte 0 carries no character.
// Output channel (out_valid / out_stall): one encoded byte per transaction;
// the terminator is out_byte 0 with last high.
// Configuration channel (cfg_valid / cfg_ready): cfg_data writes the output
// capacity; cfg_ready is always high.
// Path: an accepted item is written into the command queue, and its first
// byte is then registered into the output register, which drives out_valid.
// Throughput: the output register emits one byte per cycle while out_stall
// is low; an item yields one byte for a plain byte and three for an
// escape, plus the terminator on the end item. Items yielding
// nothing are absorbed at one per cycle while the queue has room.
// Reset: synchronous; clears string state and the queue and loads a
// capacity of 512. No clearing pass is needed.
// Output stall: the output register holds its byte; the queue keeps
// accepting until full, then in_stall rises.
module percent_escape_encoder import pee_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             end_of_string,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;

  pee_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .q_status      (q_status),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  pee_queue #(.DEPTH(DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  pee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

FILE: rtl/pee_checker.sv
// Port-level checks for the percent escape encoder, bound to the top level.
// Depends on percent_escape_encoder.
module pee_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last
);

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("output transaction changed while stalled");

  a_term_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> out_byte == 8'h00)
    else $error("terminator byte is not zero");

  // a percent sign only ever opens an escape, so a hex digit follows at once
  a_hex_after_pct: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_byte == 8'h25 |=> out_valid && !last &&
    ((out_byte >= 8'h30 && out_byte <= 8'h39) || (out_byte >= 8'h41 && out_byte <= 8'h46)))
    else $error("escape not followed by a hex digit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind percent_escape_encoder pee_port_checks u_pee_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .last      (last)
);

FILE: test/pee_checker.sv
`timescale 1ns / 1ps
// Watches the channels of percent_escape_encoder, predicts the encoded byte
// stream and compares every output transaction with it. Depends on pee_pkg.
module pee_checker import pee_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             end_of_string,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [7:0]       out_byte,
  input  logic             last,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output int               failures,
  output int               pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
  } enc_byte_t;

  enc_byte_t        encoded_q[$];
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] written;
  logic             past_first;
  logic             halted;

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic logic [7:0] hex_glyph(input logic [3:0] n);
    if (n < 4'd10) begin
      return {4'h3, n};
    end
    return 8'h37 + 8'(n);
  endfunction

  function automatic logic must_escape(input logic [7:0] c, input logic first);
    case (c)
      CH_SPACE, CH_STAR, CH_QUERY, CH_PCT: return 1'b1;
      CH_DOT: return first;
      default: return (c < CH_SPACE) || (c > CH_TILDE);
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] ch, input logic term);
    enc_byte_t e;
    e.ch   = ch;
    e.term = term;
    encoded_q.push_back(e);
  endfunction

  // Work out the bytes one input transaction yields and advance the string state.
  function automatic void encode_item(input logic [7:0] c, input logic eos);
    int unsigned room;
    int unsigned used;
    room = 32'(capacity);
    used = 32'(written);
    if (c != CH_NUL && !halted) begin
      if (must_escape(c, !past_first)) begin
        if (used + 4 < room) begin
          push_byte(CH_PCT, 1'b0);
          push_byte(hex_glyph(c[7:4]), 1'b0);
          push_byte(hex_glyph(c[3:0]), 1'b0);
          written = written + 16'd3;
        end else begin
          halted = 1'b1;
        end
      end else if (used + 1 < room) begin
        push_byte(c, 1'b0);
        written = written + 16'd1;
      end
      if (!halted) begin
        past_first = 1'b1;
      end
    end
    // The terminator goes out whatever the count.
    if (eos) begin
      push_byte(CH_NUL, 1'b1);
      past_first = 1'b0;
      written    = '0;
      halted     = 1'b0;
    end
  endfunction

  task automatic log_failure(input string what, input enc_byte_t want);
    if (failures < 10) begin
      $display("%0t: %s: expected byte %h last %b, got byte %h last %b",
               $realtime, what, want.ch, want.term, out_byte, last);
    end
    failures++;
  endtask

  always @(posedge clk) begin : watch
    enc_byte_t want;
    if (rst) begin
      capacity   = CAP_RESET;
      written    = '0;
      past_first = 1'b0;
      halted     = 1'b0;
      encoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (encoded_q.size() == 0) begin
          want = '0;
          log_failure("output transaction with nothing expected", want);
        end else begin
          want = encoded_q.pop_front();
          if (want.ch !== out_byte || want.term !== last) begin
            log_failure("output mismatch", want);
          end
        end
      end
      if (in_valid && !in_stall) begin
        encode_item(in_byte, end_of_string);
      end
    end
    pending = encoded_q.size();
  end

endmodule

FILE: test/tb_percent_escape_encoder.sv
`timescale 1ns / 1ps
// Stimulus and verdict for percent_escape_encoder: directed strings, then
// random strings under four idling phases. Depends on pee_pkg and pee_checker.
module tb_percent_escape_encoder;
  import pee_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_byte = '0;
  logic             end_of_string = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  int failures;
  int pending;
  int quiet_cycles = 0;
  int chars_sent = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  percent_escape_encoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  pee_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Abort when nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Entered and left at a falling edge; valid stays high on return so that
  // back-to-back transactions need no second assignment in one step.
  task automatic send_item(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    if (b != CH_NUL || eos) begin
      chars_sent++;
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 8'($urandom_range(8'h21, 8'h7E));
    end else if (r < 70) begin
      case ($urandom_range(0, 4))
        0: return CH_SPACE;
        1: return CH_STAR;
        2: return CH_QUERY;
        3: return CH_PCT;
        default: return CH_DOT;
      endcase
    end else if (r < 92) begin
      return 8'($urandom_range(0, 255));
    end
    return CH_NUL;
  endfunction

  task automatic send_string(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(pick_char(), 1'b0);
    end
    send_item(($urandom_range(0, 1) != 0) ? pick_char() : CH_NUL, 1'b1);
  endtask

  // Drain the block, let any zero-yield items settle, then write the capacity.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Leading zero byte must not take the first position from the dot.
    send_item(CH_NUL, 1'b0);
    send_item(CH_DOT, 1'b0);
    send_item("a", 1'b0);
    send_item(CH_DOT, 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item(CH_STAR, 1'b0);
    send_item(CH_QUERY, 1'b0);
    send_item(CH_PCT, 1'b0);
    send_item(8'h1F, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_TILDE, 1'b0);
    send_item(8'h01, 1'b0);
    send_item("q", 1'b1);
    send_item(CH_NUL, 1'b1);
    send_item(CH_DOT, 1'b1);

    // Smallest capacity: plain bytes fill it, then drop, then the escape halts.
    write_capacity(16'd4);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item("c", 1'b0);
    send_item("d", 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item("e", 1'b0);
    send_item(CH_NUL, 1'b1);

    // Capacity below range: only the terminator gets out.
    write_capacity(16'd0);
    send_item("x", 1'b0);
    send_item(CH_NUL, 1'b1);

    target = chars_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          write_capacity(CAP_RESET);
        end
        1: begin
          src_idle_pct = 66;
          sink_stall_pct = 0;
          write_capacity(16'hFFFF);
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 66;
          write_capacity(16'($urandom_range(4, 12)));
        end
        default: begin
          src_idle_pct = 18;
          sink_stall_pct = 18;
          write_capacity(16'($urandom_range(4, 40)));
        end
      endcase
      target += 32;
      while (chars_sent < target) begin
        send_string($urandom_range(0, 9));
      end
    end

    in_valid <= 1'b0;
    sink_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
